[rtl/ftvm_pkg.sv]
// ----------------------------------------------------------------------------
// ftvm_pkg
// shared types, constants and helpers of the fisheye theta validity mask
// ----------------------------------------------------------------------------
package ftvm_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int MAX_ROUNDS_DEF = 20;
    localparam int FRAC_BITS      = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int ROW_BITS       = 12;
    localparam int COUNT_BITS     = 24;
    localparam int ROUND_BITS     = 5;

    localparam logic [CFG_IDX_BITS-1:0] REG_INV_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_FOCAL_Y  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_CUBIC   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FIFTH   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_SEVENTH = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_NINTH   = 3'd7;

    localparam logic signed [31:0] THETA_LIMIT      = 32'sd26340229;
    localparam int                 VALID_ROUND_LIMIT = 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q inv_focal_x;
        t_q offset_x;
        t_q inv_focal_y;
        t_q offset_y;
        t_q coef_cubic;
        t_q coef_fifth;
        t_q coef_seventh;
        t_q coef_ninth;
    } t_cfg;

    // entry of the queue between front and back
    typedef struct packed {
        logic                frame_start;
        logic                row_zero;
        logic [ROW_BITS-1:0] edge_row;
        t_q                  r;
    } t_job;

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_SQ, F_SQRT, F_HOLD} t_front_state;

    typedef enum logic [3:0] {
        S_IDLE, S_XY, S_SQ, S_SQRT, S_PHI_START, S_PHI, S_AFTER_Y, S_AFTER_Z,
        S_DIV, S_AFTER_Q, S_DONE
    } t_core_state;

    function automatic t_q sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // product of two Q8.24 values, floor shift, saturated
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic signed [65:0] q;
        p = a * b;
        q = 66'(p >>> FRAC_BITS);
        return sat32(q);
    endfunction

endpackage

[rtl/fisheye_theta_validity_mask.sv]
// ----------------------------------------------------------------------------
// fisheye_theta_validity_mask
// pixel to theta by steffensen iteration, validity and column edge count
// ----------------------------------------------------------------------------
//  channel  signals                                   role
//  pixel    i_valid/o_ready, i_pixel_col, i_pixel_row  coordinate beat in
//  result   o_valid/i_ready, o_pixel_valid .. count    one result beat out
//  config   i_cfg_valid/o_cfg_ready, index, data       register write
//
// front: accept, map, square, bitwise square root and hand-off per pixel,
// decoupled from the core by a two-entry queue
// core: each round runs two polynomial passes with their checks, the serial
// divider and the update, up to MAX_ROUNDS rounds per pixel; the divider
// sets the rate
// synchronous active-low reset clears control state and the config registers
// either side may stall; a finished result waits in the output register
// ----------------------------------------------------------------------------
module fisheye_theta_validity_mask #(
    parameter int COORD_BITS = ftvm_pkg::COORD_BITS_DEF,
    parameter int MAX_ROUNDS = ftvm_pkg::MAX_ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ftvm_pkg::CFG_IDX_BITS:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [COORD_BITS-1:0]         i_pixel_col,
    input  logic [COORD_BITS-1:0]         i_pixel_row,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_pixel_valid,
    output logic signed [31:0]            o_theta_value,
    output logic [ftvm_pkg::ROUND_BITS-1:0] o_iteration_index,
    output logic                          o_edge_found,
    output logic [ftvm_pkg::ROW_BITS-1:0] o_edge_row,
    output logic [ftvm_pkg::COUNT_BITS-1:0] o_edge_count
);
    import ftvm_pkg::*;

    t_cfg r_cfg;
    t_job w_fjob, w_qjob;
    logic w_fv, w_fr, w_qv, w_qr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && !i_cfg_index[CFG_IDX_BITS]) begin
            case (i_cfg_index[CFG_IDX_BITS-1:0])
                REG_INV_FOCAL_X:  r_cfg.inv_focal_x  <= i_cfg_data;
                REG_OFFSET_X:     r_cfg.offset_x     <= i_cfg_data;
                REG_INV_FOCAL_Y:  r_cfg.inv_focal_y  <= i_cfg_data;
                REG_OFFSET_Y:     r_cfg.offset_y     <= i_cfg_data;
                REG_COEF_CUBIC:   r_cfg.coef_cubic   <= i_cfg_data;
                REG_COEF_FIFTH:   r_cfg.coef_fifth   <= i_cfg_data;
                REG_COEF_SEVENTH: r_cfg.coef_seventh <= i_cfg_data;
                REG_COEF_NINTH:   r_cfg.coef_ninth   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ftvm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_col(i_pixel_col), .i_row(i_pixel_row),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fjob)
    );

    ftvm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fjob),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qjob)
    );

    ftvm_core #(.MAX_ROUNDS(MAX_ROUNDS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_job_valid(w_qv), .o_job_ready(w_qr), .i_job(w_qjob),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pixel_valid(o_pixel_valid), .o_theta_value(o_theta_value),
        .o_iteration_index(o_iteration_index), .o_edge_found(o_edge_found),
        .o_edge_row(o_edge_row), .o_edge_count(o_edge_count)
    );
endmodule

[rtl/ftvm_front.sv]
// ----------------------------------------------------------------------------
// ftvm_front
// maps a pixel through the inverse intrinsics and takes the radius
// ----------------------------------------------------------------------------
module ftvm_front #(
    parameter int COORD_BITS = ftvm_pkg::COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ftvm_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_BITS-1:0]  i_col,
    input  logic [COORD_BITS-1:0]  i_row,
    output logic                   o_job_valid,
    input  logic                   i_job_ready,
    output ftvm_pkg::t_job         o_job
);
    import ftvm_pkg::*;

    t_front_state r_state, n_state;
    logic [COORD_BITS-1:0] r_col, r_row;
    t_q r_x, r_y;
    logic [63:0] r_rem, r_res, r_bit;
    t_job r_job;

    logic signed [65:0] w_x, w_y;
    assign w_x = 66'(i_cfg.inv_focal_x * $signed({1'b0, r_col})) + 66'(i_cfg.offset_x);
    assign w_y = 66'(i_cfg.inv_focal_y * $signed({1'b0, r_row})) + 66'(i_cfg.offset_y);

    assign o_ready     = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_HOLD);
    assign o_job       = r_job;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_MUL;
            F_MUL:   n_state = F_SQ;
            F_SQ:    n_state = F_SQRT;
            F_SQRT:  if (r_bit == 64'd0) n_state = F_HOLD;
            F_HOLD:  if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            F_IDLE: begin
                r_col <= i_col;
                r_row <= i_row;
                r_job.frame_start <= (i_col == '0) && (i_row == '0);
                r_job.row_zero    <= (i_row == '0);
                r_job.edge_row    <= ROW_BITS'(32'(i_row) - 32'd1);
            end
            F_MUL: begin
                r_x <= sat32(w_x);
                r_y <= sat32(w_y);
            end
            F_SQ: begin
                r_rem <= 64'(r_x * r_x) + 64'(r_y * r_y);
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            F_SQRT: begin
                // one result bit per cycle
                if (r_bit != 64'd0) begin
                    if (r_rem >= r_res + r_bit) begin
                        r_rem <= r_rem - (r_res + r_bit);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_job.r <= (r_res > 64'h7fff_ffff) ? 32'sh7fffffff : r_res[31:0];
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/ftvm_queue.sv]
// ----------------------------------------------------------------------------
// ftvm_queue
// two-entry queue between the front and the iteration core
// ----------------------------------------------------------------------------
module ftvm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ftvm_pkg::t_job i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ftvm_pkg::t_job o_data
);
    import ftvm_pkg::*;

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
        if (i_valid && o_ready) r_mem[r_wp] <= i_data;
    end
endmodule

[rtl/ftvm_core.sv]
// ----------------------------------------------------------------------------
// ftvm_core
// steffensen iteration on four multipliers and a serial divider, edge count
// ----------------------------------------------------------------------------
module ftvm_core #(
    parameter int MAX_ROUNDS = ftvm_pkg::MAX_ROUNDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ftvm_pkg::t_cfg               i_cfg,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  ftvm_pkg::t_job               i_job,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_pixel_valid,
    output logic signed [31:0]           o_theta_value,
    output logic [ftvm_pkg::ROUND_BITS-1:0] o_iteration_index,
    output logic                         o_edge_found,
    output logic [ftvm_pkg::ROW_BITS-1:0] o_edge_row,
    output logic [ftvm_pkg::COUNT_BITS-1:0] o_edge_count
);
    import ftvm_pkg::*;

    localparam int RB = $clog2(MAX_ROUNDS + 1);

    t_core_state r_state, n_state;
    t_job r_job;
    t_q r_xk, r_yk, r_zk, r_theta, r_arg, r_phi;
    t_q r_t2, r_tp;
    logic signed [33:0] r_sum;
    logic [3:0] r_pstep;
    logic       r_second;
    logic [RB-1:0] r_round, r_done;
    // divider
    logic [63:0] r_num, r_quo;
    logic [32:0] r_den;
    logic [64:0] r_rem;
    logic [6:0] r_dcnt;
    logic r_neg;
    logic r_prev_valid;
    logic [COUNT_BITS-1:0] r_total;
    logic r_out_valid;

    logic signed [33:0] w_dy, w_dp, w_dz, w_dq;
    logic signed [34:0] w_den;
    t_q w_d, w_num, w_dens, w_th;
    t_q w_q1, w_q2;
    logic signed [65:0] w_sum;
    logic signed [65:0] w_quo_s;
    logic [64:0] w_rsh;
    logic w_valid;
    logic w_edge;

    // r_phi holds the fresh y or z value in the check states
    assign w_dy  = 34'(r_yk) - 34'(r_xk);
    assign w_dp  = 34'(r_phi) - 34'(r_xk);
    assign w_dz  = 34'(r_yk) - 34'(r_phi);
    assign w_den = 35'(r_phi) - 35'(r_yk) - 35'(r_yk) + 35'(r_xk);
    assign w_dens = sat32(66'(w_den));
    assign w_d   = sat32(66'(w_dy));
    assign w_num = qmul(w_d, w_d);
    // one coefficient product per summing phi step
    assign w_q1  = qmul(r_t2, r_tp);
    always_comb begin
        case (r_pstep)
            4'd2:    w_q2 = qmul(i_cfg.coef_cubic, r_tp);
            4'd3:    w_q2 = qmul(i_cfg.coef_fifth, r_tp);
            4'd4:    w_q2 = qmul(i_cfg.coef_seventh, r_tp);
            default: w_q2 = qmul(i_cfg.coef_ninth, r_tp);
        endcase
    end
    assign w_sum   = 66'(r_sum) + 66'(w_q2);
    assign w_rsh   = {r_rem[63:0], r_num[63]};
    assign w_quo_s = r_neg ? -66'($signed({2'b00, r_quo})) : 66'($signed({2'b00, r_quo}));
    assign w_th    = sat32(66'(r_xk) - 66'(sat32(w_quo_s)));
    assign w_dq    = 34'(r_zk) - 34'(w_th);

    assign w_valid = (32'(r_done) <= VALID_ROUND_LIMIT) && (r_theta >= 0)
                     && (r_theta <= THETA_LIMIT);
    assign w_edge  = !r_job.row_zero && (w_valid != r_prev_valid);

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_job_valid) n_state = S_PHI_START;
            S_PHI_START: n_state = S_PHI;
            S_PHI:       if (r_pstep == 4'd6) n_state = r_second ? S_AFTER_Z : S_AFTER_Y;
            S_AFTER_Y:   n_state = ((w_dp <= 1) && (w_dp >= -1)) ? S_DONE : S_PHI_START;
            S_AFTER_Z: begin
                if ((w_dz <= 1) && (w_dz >= -1)) n_state = S_DONE;
                else if (w_den == 0) n_state = S_DONE;
                else n_state = S_DIV;
            end
            S_DIV:       if (r_dcnt == 7'd64) n_state = S_AFTER_Q;
            S_AFTER_Q: begin
                if (((w_dq <= 1) && (w_dq >= -1)) || (32'(r_round) + 1 >= MAX_ROUNDS))
                    n_state = S_DONE;
                else n_state = S_PHI_START;
            end
            S_DONE:      if (!r_out_valid || i_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_valid <= 1'b0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid  <= 1'b1;
                r_prev_valid <= w_valid;
                if (r_job.frame_start) begin
                    r_total <= COUNT_BITS'(w_edge);
                end else if (w_edge && r_total != COUNT_MAX) begin
                    r_total <= r_total + 1'b1;
                end
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_job   <= i_job;
                r_theta <= i_job.r;
                r_xk    <= i_job.r;
                r_arg   <= i_job.r;
                r_round <= '0;
                r_done  <= '0;
                r_second <= 1'b0;
            end
            S_PHI_START: begin
                r_pstep <= 4'd0;
                r_tp    <= r_arg;
                r_t2    <= r_arg;
                r_sum   <= '0;
            end
            S_PHI: begin
                // steps: t2, t3, then t5..t9 with coefficient sums, then phi as r minus the sum
                r_pstep <= r_pstep + 4'd1;
                case (r_pstep)
                    4'd0: begin
                        r_t2 <= qmul(r_arg, r_arg);
                    end
                    4'd1: r_tp <= w_q1;
                    4'd2, 4'd3, 4'd4: begin
                        r_sum <= w_sum[33:0];
                        r_tp  <= w_q1;
                    end
                    4'd5: r_sum <= w_sum[33:0];
                    default: r_phi <= sat32(66'(r_job.r) - 66'(r_sum));
                endcase
            end
            S_AFTER_Y: begin
                r_yk <= r_phi;
                r_theta <= r_phi;
            end
            S_AFTER_Z: begin
                r_zk    <= r_phi;
                r_theta <= r_phi;
                r_neg   <= w_num[31] ^ w_den[34];
                r_num   <= {8'(0), w_num[31] ? 32'(-w_num) : 32'(w_num), 24'd0};
                r_den   <= w_den[34] ? 33'(-34'(w_dens)) : 33'(w_dens);
                r_rem   <= '0;
                r_quo   <= '0;
                r_dcnt  <= '0;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (r_dcnt != 7'd64) begin
                    r_dcnt <= r_dcnt + 7'd1;
                    r_num  <= r_num << 1;
                    if (w_rsh >= 65'(r_den)) begin
                        r_rem <= w_rsh - 65'(r_den);
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                end
            end
            S_AFTER_Q: begin
                r_theta <= w_th;
                r_xk    <= w_th;
                r_arg   <= w_th;
                r_second <= 1'b0;
                if (!((w_dq <= 1) && (w_dq >= -1))) begin
                    r_done  <= r_round;
                    r_round <= r_round + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_pixel_valid     <= w_valid;
                    o_theta_value     <= r_theta;
                    o_iteration_index <= (32'(r_done) > 31) ? 5'd31 : 5'(r_done);
                    o_edge_found      <= w_edge;
                    o_edge_row        <= r_job.row_zero ? '0 : r_job.edge_row;
                    o_edge_count      <= r_job.frame_start ? COUNT_BITS'(w_edge)
                                       : ((w_edge && r_total != COUNT_MAX) ? r_total + 1'b1
                                                                           : r_total);
                end
            end
            default: ;
        endcase
        // the phi output feeds z on the second evaluation of a round
        if (r_state == S_AFTER_Y) begin
            r_arg    <= r_phi;
            r_second <= 1'b1;
        end
    end
endmodule

[rtl/ftvm_checker.sv]
// ----------------------------------------------------------------------------
// ftvm_checker
// port-level checks of the fisheye theta validity mask
// ----------------------------------------------------------------------------
module ftvm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_pixel_valid,
    input logic        o_edge_found,
    input logic [11:0] o_edge_row,
    input logic [23:0] o_edge_count
);
    // a held result beat keeps its validity, edge flag, edge row and count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid
            && $stable({o_pixel_valid, o_edge_found, o_edge_row, o_edge_count}))
        else $error("result changed while stalled");

    // an edge beat always has a nonzero count
    a_edge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_edge_found |-> o_edge_count != 24'd0)
        else $error("edge without count");

    // no edge is ever reported for row zero
    a_no_edge_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_edge_found |-> o_edge_row != 12'hfff)
        else $error("edge at row zero");
endmodule

bind fisheye_theta_validity_mask ftvm_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_pixel_valid(o_pixel_valid), .o_edge_found(o_edge_found),
    .o_edge_row(o_edge_row), .o_edge_count(o_edge_count)
);

[tb/tb_ftvm_checker.sv]
// ----------------------------------------------------------------------------
// tb_ftvm_checker
// watches the pixel, result and register channels, predicts each result and
// compares it field by field with the beat that leaves the block
// ----------------------------------------------------------------------------
module tb_ftvm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ftvm_pkg::CFG_IDX_BITS:0] i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_pix_valid,
    input  logic                            i_pix_ready,
    input  logic [11:0]                     i_pixel_col,
    input  logic [11:0]                     i_pixel_row,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic                            i_pixel_valid,
    input  logic signed [31:0]              i_theta_value,
    input  logic [4:0]                      i_iteration_index,
    input  logic                            i_edge_found,
    input  logic [11:0]                     i_edge_row,
    input  logic [23:0]                     i_edge_count,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ftvm_pkg::*;

    typedef struct {
        logic              pix_ok;
        logic signed [31:0] theta;
        logic [4:0]        rounds;
        logic              edge_hit;
        logic [11:0]       edge_at;
        logic [23:0]       count;
    } mask_beat_t;

    mask_beat_t mask_q[$];
    longint     lens[8];
    logic       last_ok;
    logic [23:0] edge_total;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return (res > 64'd2147483647) ? 64'sd2147483647 : longint'(res);
    endfunction

    // one fixed-point map step: r minus the odd distortion series
    function automatic longint distort_step(longint r, longint t);
        longint t2, t3, t5, t7, t9, s;
        t2 = fxmul(t, t);
        t3 = fxmul(t2, t);
        t5 = fxmul(t3, t2);
        t7 = fxmul(t5, t2);
        t9 = fxmul(t7, t2);
        s = fxmul(lens[4], t3) + fxmul(lens[5], t5) + fxmul(lens[6], t7)
            + fxmul(lens[7], t9);
        return clamp32(r - s);
    endfunction

    function automatic longint absd(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic mask_beat_t solve_pixel(logic [11:0] col, logic [11:0] row);
        mask_beat_t e;
        longint x, y, r, th, xk, yk, zk, den, d, num, q, done;
        x = clamp32(lens[0] * longint'(col) + lens[1]);
        y = clamp32(lens[2] * longint'(row) + lens[3]);
        r = root_floor(longint'(x * x) + longint'(y * y));
        th = r;
        done = 0;
        for (int j = 0; j < 20; j++) begin
            xk = th;
            yk = distort_step(r, xk);
            th = yk;
            if (absd(yk, xk) <= 1) break;
            zk = distort_step(r, yk);
            th = zk;
            if (absd(yk, zk) <= 1) break;
            den = zk - yk - yk + xk;
            if (den == 0) break;
            den = clamp32(den);
            d = clamp32(yk - xk);
            num = fxmul(d, d);
            q = clamp32((num * (64'sd1 << FRAC_BITS)) / den);
            th = clamp32(xk - q);
            if (absd(zk, th) <= 1) break;
            done = j;
        end
        e.pix_ok = (done <= VALID_ROUND_LIMIT && th >= 0 && th <= THETA_LIMIT);
        e.theta = th[31:0];
        e.rounds = (done > 31) ? 5'd31 : done[4:0];
        e.edge_hit = 1'b0;
        e.edge_at = '0;
        if (col == 0 && row == 0) edge_total = '0;
        if (row != 0) begin
            e.edge_at = row - 12'd1;
            if (e.pix_ok != last_ok) begin
                e.edge_hit = 1'b1;
                if (edge_total != COUNT_MAX) edge_total++;
            end
        end
        last_ok = e.pix_ok;
        e.count = edge_total;
        return e;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        mask_beat_t e;
        if (!i_rst_n) begin
            foreach (lens[i]) lens[i] = 0;
            last_ok = 1'b0;
            edge_total = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < 8)
                lens[i_cfg_index[CFG_IDX_BITS-1:0]] = longint'($signed(i_cfg_data));
            if (i_pix_valid && i_pix_ready)
                mask_q.insert(mask_q.size(), solve_pixel(i_pixel_col, i_pixel_row));
            if (i_res_valid && i_res_ready) begin
                if (mask_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    e = mask_q.pop_front();
                    if (e.pix_ok !== i_pixel_valid || e.theta !== i_theta_value ||
                        e.rounds !== i_iteration_index || e.edge_hit !== i_edge_found ||
                        e.edge_at !== i_edge_row || e.count !== i_edge_count) begin
                        $display("%0t: mismatch valid/theta/iter/edge/row/count", $realtime);
                        $display("  expected %0b %0d %0d %0b %0d %0d", e.pix_ok, e.theta,
                                 e.rounds, e.edge_hit, e.edge_at, e.count);
                        $display("  actual   %0b %0d %0d %0b %0d %0d", i_pixel_valid,
                                 i_theta_value, i_iteration_index, i_edge_found,
                                 i_edge_row, i_edge_count);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = mask_q.size();
    end
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// pixel and register stimulus for the fisheye theta validity mask: directed
// corners, then column scans under several lens settings with random stalls
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ftvm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [11:0] i_pixel_col;
    logic [11:0] i_pixel_row;
    logic        o_valid;
    logic        i_ready;
    logic        o_pixel_valid;
    logic signed [31:0] o_theta_value;
    logic [4:0]  o_iteration_index;
    logic        o_edge_found;
    logic [11:0] o_edge_row;
    logic [23:0] o_edge_count;
    int          errors;
    int          pending;
    bit          quiet;
    bit          long_hold;

    fisheye_theta_validity_mask u_dut (.*);

    tb_ftvm_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_pix_valid(i_valid), .i_pix_ready(o_ready),
        .i_pixel_col(i_pixel_col), .i_pixel_row(i_pixel_row),
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_pixel_valid(o_pixel_valid), .i_theta_value(o_theta_value),
        .i_iteration_index(o_iteration_index), .i_edge_found(o_edge_found),
        .i_edge_row(o_edge_row), .i_edge_count(o_edge_count),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("** fisheye_theta_validity_mask: FAILED **");
        $finish;
    end

    // result side backpressure
    initial begin
        i_ready = 1'b0;
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
    endtask

    task automatic load_lens(logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) write_reg(i[3:0], v[i]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // well-formed frames of column scans, with some stray coordinates
    task automatic scan_frames(int n_items);
        int sent;
        logic [11:0] col, rows;
        sent = 0;
        col = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_pixel(12'($urandom), 12'($urandom));
                sent++;
            end else begin
                if ($urandom_range(0, 5) == 0) col = 0;
                rows = 12'($urandom_range(1, 12));
                for (int r = 0; r <= rows && sent < n_items; r++) begin
                    send_pixel(col, 12'(r * $urandom_range(1, 8)));
                    sent++;
                end
                col = ($urandom_range(0, 9) == 0) ? 12'($urandom) : col + 12'd1;
            end
        end
    endtask

    function automatic logic [31:0] rnd_range(int lo, int hi);
        return 32'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    initial begin
        logic [31:0] lens[8];
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel_col = '0;
        i_pixel_row = '0;
        quiet = 1'b0;
        long_hold = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lens: everything maps to zero
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // plausible lens, directed corners and frame boundaries
        lens = '{32'd60000, -32'sd33554432, 32'd60000, -32'sd25165824,
                 32'sd1000000, -32'sd200000, 32'sd30000, -32'sd2000};
        load_lens(lens);
        write_reg(4'd8, 32'hffffffff);
        write_reg(4'd15, 32'h12345678);
        i_cfg_valid <= 1'b0;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2730, 12'd1365);
        send_pixel(12'd1365, 12'd2730);
        send_pixel(12'd0, 12'd0);
        for (int r = 0; r < 10; r++) send_pixel(12'd559, 12'(r * 100));
        drain();

        // extremes: saturation everywhere, then all minimum
        lens = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        load_lens(lens);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd1);
        send_pixel(12'd1, 12'd4095);
        drain();
        lens = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
        load_lens(lens);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd2);
        send_pixel(12'd2, 12'd4095);
        drain();

        // random lenses with column scans; the first one rides a long stall
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < 8; i += 2) begin
                lens[i] = (i < 4) ? rnd_range(2000, 400000) : rnd_range(-4000000, 4000000);
                lens[i+1] = (i < 4) ? rnd_range(-70000000, 0) : rnd_range(-400000, 400000);
            end
            if (ph == 3) lens[1] = 32'($urandom);
            load_lens(lens);
            if (ph == 0) long_hold = 1'b1;
            scan_frames(100);
            drain();
        end

        // last stretch without idling on either side
        quiet = 1'b1;
        scan_frames(60);
        drain();
        repeat (200) @(posedge i_clk);

        if (errors == 0 && pending == 0) begin
            $display("** fisheye_theta_validity_mask: PASSED **");
        end else begin
            $display("** fisheye_theta_validity_mask: FAILED **");
        end
        $finish;
    end
endmodule
